>>> rtl/sqw_pkg.sv
// Package for the sleep queue wake-up block: word types, codes, defaults and
// the command/status structs between controller and datapath.
// No dependencies.
package sqw_pkg;

    // Field widths fixed by the word formats
    localparam int ID_W   = 8;
    localparam int DUR_W  = 32;
    localparam int TICK_W = 64;

    // Parameter defaults
    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 8;

    // Request mode
    localparam logic MODE_SLEEP = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Response kind
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WAKE   = 1'b1;

    // Response status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic                    mode;
        logic [ID_W-1:0]         thread_id;
        logic signed [DUR_W-1:0] duration;
    } req_t;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] woken_id;
        logic [1:0]      status;
        logic            last;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic sleep_go;  // take a sleep request
        logic tick_go;   // take a tick, start the scan
        logic step;      // process the entry at the scan index
        logic fin;       // close the scan, flush the held notice
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic occ_zero;
        logic due;
        logic pend_valid;
        logic out_free;
        logic scan_last;
    } dp_stat_t;

endpackage

>>> rtl/sqw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sqw_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sqw_datapath.sv
// Datapath: tick counter, queue occupancy, queue RAM, scan pointers,
// held wake notice and the output word register.
// Depends on sqw_pkg and sqw_ram.
module sqw_datapath #(
    parameter int SLOTS   = sqw_pkg::SLOTS_DEF,
    parameter int ID_BITS = sqw_pkg::ID_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sqw_pkg::req_t     req,
    input  sqw_pkg::ctrl_cmd_t cmd,
    output sqw_pkg::dp_stat_t stat,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sqw_pkg::rsp_t     rsp
);
    import sqw_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int EW = KW + TICK_W;
    localparam logic [CW-1:0] SLOTS_CW = CW'(SLOTS);

    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     keep_reg, keep_next;
    logic [KW-1:0]     pend_id_reg, pend_id_next;
    logic              pend_valid_reg, pend_valid_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [CW-1:0]     idx_p1;
    logic [KW-1:0]     req_id;
    logic [TICK_W:0]   wake_sum;
    logic [TICK_W-1:0] wake;
    logic              dur_bad;
    logic              q_full;
    logic              sleep_ok;
    logic [1:0]        sleep_st;
    logic              out_free;
    logic              out_load;
    logic              due;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [EW-1:0]     wdata;
    logic [AW-1:0]     raddr;
    logic [EW-1:0]     rdata;
    logic [KW-1:0]     rd_id;
    logic [TICK_W-1:0] rd_wake;

    // Queue storage
    sqw_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS),
        .AW   (AW)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_id   = rdata[EW-1:TICK_W];
    assign rd_wake = rdata[TICK_W-1:0];

    // Sleep request: status and saturating wake time
    assign req_id   = req.thread_id[KW-1:0];
    assign wake_sum = {1'b0, tick_reg} + {{(TICK_W - DUR_W + 1){1'b0}}, req.duration};
    assign wake     = wake_sum[TICK_W] ? {TICK_W{1'b1}} : wake_sum[TICK_W-1:0];
    assign dur_bad  = req.duration[DUR_W-1] || (req.duration == '0);
    assign q_full   = (occ_reg == SLOTS_CW);
    assign sleep_ok = !dur_bad && !q_full;
    assign sleep_st = dur_bad ? ST_IGNORED : (q_full ? ST_FULL : ST_OK);

    // Scan compare and pointers
    assign idx_p1 = idx_reg + CW'(1);
    assign due    = (rd_wake <= tick_reg);

    // RAM ports: append on sleep, compact on a kept entry
    assign we    = (cmd.sleep_go && sleep_ok) || (cmd.step && !due);
    assign waddr = cmd.sleep_go ? occ_reg[AW-1:0] : keep_reg[AW-1:0];
    assign wdata = cmd.sleep_go ? {req_id, wake} : rdata;
    assign raddr = cmd.step ? idx_p1[AW-1:0] : idx_reg[AW-1:0];

    assign out_free = !out_valid_reg || !rsp_stall;

    // Next-state logic
    always_comb
    begin
        tick_next       = tick_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        pend_id_next    = pend_id_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_load        = 1'b0;

        if (cmd.sleep_go)
        begin
            out_load          = 1'b1;
            out_next.kind     = KIND_STATUS;
            out_next.woken_id = ID_W'(req_id);
            out_next.status   = sleep_st;
            out_next.last     = 1'b1;
            if (sleep_ok)
            begin
                occ_next = occ_reg + CW'(1);
            end
        end

        if (cmd.tick_go)
        begin
            tick_next       = tick_reg + TICK_W'(1);
            idx_next        = '0;
            keep_next       = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.step)
        begin
            idx_next = idx_p1;
            if (due)
            begin
                // earlier notice is not the last one
                if (pend_valid_reg)
                begin
                    out_load          = 1'b1;
                    out_next.kind     = KIND_WAKE;
                    out_next.woken_id = ID_W'(pend_id_reg);
                    out_next.status   = ST_OK;
                    out_next.last     = 1'b0;
                end
                pend_id_next    = rd_id;
                pend_valid_next = 1'b1;
            end
            else
            begin
                keep_next = keep_reg + CW'(1);
            end
        end

        if (cmd.fin)
        begin
            if (pend_valid_reg)
            begin
                out_load          = 1'b1;
                out_next.kind     = KIND_WAKE;
                out_next.woken_id = ID_W'(pend_id_reg);
                out_next.status   = ST_OK;
                out_next.last     = 1'b1;
            end
            occ_next        = keep_reg;
            idx_next        = '0;
            keep_next       = '0;
            pend_valid_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && rsp_stall;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            occ_reg        <= '0;
            idx_reg        <= '0;
            keep_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_reg       <= tick_next;
            occ_reg        <= occ_next;
            idx_reg        <= idx_next;
            keep_reg       <= keep_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign stat.occ_zero   = (occ_reg == '0);
    assign stat.due        = due;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;
    assign stat.scan_last  = (idx_p1 == occ_reg);

    // Checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= SLOTS_CW)
        else $error("queue occupancy above slot count");

    a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
        keep_reg <= idx_reg)
        else $error("compaction pointer ahead of scan pointer");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output word overwritten while stalled");

    a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_go |=> tick_reg == $past(tick_reg) + TICK_W'(1))
        else $error("tick counter did not advance");

endmodule

>>> rtl/sqw_ctrl.sv
// Controller state machine: request acceptance and the tick scan sequence.
// Depends on sqw_pkg.
module sqw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_mode,
    output logic               req_stall,
    input  sqw_pkg::dp_stat_t  stat,
    output sqw_pkg::ctrl_cmd_t cmd
);
    import sqw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign req_stall = !((state_reg == S_IDLE) && stat.out_free);
    assign accept    = req_valid && !req_stall;

    // Sequencing
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_mode == MODE_TICK)
                    begin
                        cmd.tick_go = 1'b1;
                        if (!stat.occ_zero)
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        cmd.sleep_go = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                // a due entry pushes out the held notice; wait for room
                if (!(stat.due && stat.pend_valid && !stat.out_free))
                begin
                    cmd.step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/sleep_queue_wakeup_top.sv
// Top level of the sleep queue wake-up block.
// Depends on sqw_pkg, sqw_ctrl, sqw_datapath (and sqw_ram below it).
//
// Usage:
//   req channel (req_valid/req_stall/req): one word per sleep request
//   (mode 0) or timer tick (mode 1). rsp channel (rsp_valid/rsp_stall/rsp):
//   result words, each with a last flag on the final word of its request.
//   A sleep request yields one status word in the cycle after acceptance:
//   accepted (queued with wake time = count + duration, saturating),
//   ignored (duration of zero or less) or full (SLOTS entries queued).
//   A tick increments the 64-bit counter, then scans the queue from the
//   head, one entry per cycle from the queue RAM's read port unless a
//   wake word waits for room, emitting a wake word for each due entry and
//   compacting the rest in order. A tick with an empty queue does not scan
//   and gives no words. Wake words come out at most one per cycle, each
//   held until the scan finds the next due entry or the scan closes.
//   One request is in flight at a time; req_stall is high while a scan
//   runs or while an undelivered word blocks the output register.
//   When rsp_stall is high the output word holds.
//   Reset clears the counter and the queue; no clearing pass is needed.
module sleep_queue_wakeup_top #(
    parameter int SLOTS   = sqw_pkg::SLOTS_DEF,
    parameter int ID_BITS = sqw_pkg::ID_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sqw_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sqw_pkg::rsp_t rsp
);
    import sqw_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    sqw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_mode (req.mode),
        .req_stall(req_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sqw_datapath #(
        .SLOTS  (SLOTS),
        .ID_BITS(ID_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .stat     (stat),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for sleep_queue_wakeup_top: directed corner words, then random
// sleep/tick traffic, checked word by word against an in-bench queue predictor.
// Depends on sqw_pkg and the RTL under rtl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sqw_pkg::*;

    localparam int QUEUE_DEPTH  = SLOTS_DEF;
    localparam int RANDOM_WORDS = 300;
    localparam int IDLE_PCT     = 18;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Set during a calm stretch: neither side idles
    bit no_idle = 1'b0;
    int words_sent = 0;
    int words_seen = 0;
    int mismatch_count = 0;

    // Predicted block state
    logic [TICK_W-1:0] now_ticks = '0;
    logic [ID_W-1:0]   slot_id  [QUEUE_DEPTH];
    logic [TICK_W-1:0] slot_due [QUEUE_DEPTH];
    int slot_count = 0;

    // Result words still owed by the block, oldest first
    rsp_t awaited_words[$];
    rsp_t head_word;

    sleep_queue_wakeup_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one accepted word to the predicted state, queue the words it owes
    task automatic advance_alarm_state(input req_t w);
        logic [TICK_W:0] sum;
        rsp_t r;
        int n_due;
        int woken;
        int kept;
        begin
            if (w.mode == MODE_SLEEP)
            begin
                r.kind     = KIND_STATUS;
                r.woken_id = w.thread_id;
                r.last     = 1'b1;
                if (w.duration <= 0)
                    r.status = ST_IGNORED;
                else if (slot_count >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // wake time saturates at all ones
                    sum = {1'b0, now_ticks} + {{(TICK_W - DUR_W + 1){1'b0}}, w.duration};
                    slot_id[slot_count]  = w.thread_id;
                    slot_due[slot_count] = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
                    slot_count++;
                    r.status = ST_OK;
                end
                awaited_words.push_back(r);
            end
            else
            begin
                now_ticks = now_ticks + 1'b1;
                n_due = 0;
                for (int i = 0; i < slot_count; i++)
                    if (slot_due[i] <= now_ticks)
                        n_due++;
                // emit due entries in queue order, compact the rest
                woken = 0;
                kept  = 0;
                for (int i = 0; i < slot_count; i++)
                begin
                    if (slot_due[i] <= now_ticks)
                    begin
                        woken++;
                        r.kind     = KIND_WAKE;
                        r.woken_id = slot_id[i];
                        r.status   = ST_OK;
                        r.last     = (woken == n_due);
                        awaited_words.push_back(r);
                    end
                    else
                    begin
                        slot_id[kept]  = slot_id[i];
                        slot_due[kept] = slot_due[i];
                        kept++;
                    end
                end
                slot_count = kept;
            end
        end
    endtask

    function automatic req_t sleep_word(input logic [ID_W-1:0] id,
                                        input logic signed [DUR_W-1:0] dur);
        req_t w;
        w.mode      = MODE_SLEEP;
        w.thread_id = id;
        w.duration  = dur;
        return w;
    endfunction

    // Tick with junk in the ignored fields
    function automatic req_t tick_word();
        req_t w;
        w.mode      = MODE_TICK;
        w.thread_id = ID_W'($urandom_range(0, 255));
        w.duration  = $urandom;
        return w;
    endfunction

    // Random mode; sleeps here never queue (zero or negative duration)
    function automatic req_t noise_word();
        req_t w;
        w.mode      = 1'($urandom_range(0, 1));
        w.thread_id = ID_W'($urandom_range(0, 255));
        w.duration  = ($urandom_range(0, 3) == 0) ? '0 : ($urandom | 32'h8000_0000);
        return w;
    endfunction

    // Send one word, with random idle cycles ahead of it
    task automatic send_word(input req_t w);
        begin
            while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
            req_valid <= 1'b1;
            req       <= w;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            advance_alarm_state(w);
            words_sent++;
        end
    endtask

    // Result side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("rsp word %0d unexpected: kind=%0d id=%0d status=%0d last=%0d",
                             words_seen, rsp.kind, rsp.woken_id, rsp.status, rsp.last);
            end
            else
            begin
                head_word = awaited_words.pop_front();
                if (rsp.kind !== head_word.kind || rsp.woken_id !== head_word.woken_id ||
                    rsp.status !== head_word.status || rsp.last !== head_word.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"rsp word %0d: expected kind=%0d id=%0d status=%0d last=%0d,",
                                  " got kind=%0d id=%0d status=%0d last=%0d"},
                                 words_seen, head_word.kind, head_word.woken_id,
                                 head_word.status, head_word.last,
                                 rsp.kind, rsp.woken_id, rsp.status, rsp.last);
                end
            end
            words_seen++;
        end
        rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Tick on an empty queue gives nothing
    task automatic test_empty_tick();
        begin
            send_word(tick_word());
        end
    endtask

    // Zero, minus one and most negative durations are ignored
    task automatic test_ignored_durations();
        begin
            send_word(sleep_word(8'h00, 32'sd0));
            send_word(sleep_word(8'hFF, -32'sd1));
            send_word(sleep_word(8'hA5, 32'sh8000_0000));
        end
    endtask

    // Several wake on one tick, in queue order; survivors keep their order
    task automatic test_wake_order();
        begin
            send_word(sleep_word(8'h5A, 32'sd1));
            send_word(sleep_word(8'h00, 32'sd3));
            send_word(sleep_word(8'hFF, 32'sd2));
            send_word(sleep_word(8'h01, 32'sd1));
            send_word(sleep_word(8'h80, 32'sd2));
            send_word(tick_word());
            send_word(tick_word());
            send_word(tick_word());
        end
    endtask

    // Largest duration queues an entry that stays; ticks with nothing due
    task automatic test_long_sleeper();
        begin
            send_word(sleep_word(8'h7E, 32'sh7FFF_FFFF));
            send_word(tick_word());
            send_word(tick_word());
        end
    endtask

    // Mostly sleep batches followed by ticks, some queue-full bursts, some noise
    task automatic test_random_traffic();
        int base;
        int pick;
        int seq;
        begin
            base = words_sent;
            seq  = 0;
            while (words_sent - base < RANDOM_WORDS)
            begin
                no_idle = (words_sent - base >= 120) && (words_sent - base < 190);
                pick = $urandom_range(0, 99);
                if (seq % 12 == 5)
                begin
                    // overfill, then tick until every short sleeper is due
                    repeat (QUEUE_DEPTH + 2)
                        send_word(sleep_word(ID_W'($urandom_range(0, 255)),
                                             $urandom_range(1, 30)));
                    repeat (31)
                        send_word(tick_word());
                end
                else if (pick < 75)
                begin
                    repeat ($urandom_range(1, 6))
                        send_word(sleep_word(ID_W'($urandom_range(0, 255)),
                                             $urandom_range(1, 24)));
                    repeat ($urandom_range(1, 8))
                        send_word(tick_word());
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_word(noise_word());
                end
                seq++;
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_tick();
        test_ignored_durations();
        test_wake_order();
        test_long_sleeper();
        test_random_traffic();

        req_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_words.size() == 0)
            $display("sleep_queue_wakeup_top: match");
        else
            $display("sleep_queue_wakeup_top: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400_000;
        $display("sleep_queue_wakeup_top: mismatch");
        $finish;
    end

endmodule
